### rtl/pdr_pkg.sv
// shared types, constants and control-store program for the pi duty regulator
package pdr_pkg;

    // pwm resolution and derived compare scale
    localparam int PWM_BITS = 16;
    localparam logic [16:0] PWM_MAX = 17'((1 << PWM_BITS) - 1);

    // duty limits in q0.15
    localparam int DUTY_LO = 3277;
    localparam int DUTY_HI = 29491;

    // register reset values
    localparam logic [15:0] RST_TARGET = 16'd6144;
    localparam logic [15:0] RST_PROP   = 16'd205;
    localparam logic [15:0] RST_INTEG  = 16'd41;
    localparam logic [15:0] RST_PERIOD = 16'd655;
    localparam logic [15:0] RST_LOW    = 16'hC000;
    localparam logic [15:0] RST_HIGH   = 16'h4000;
    localparam logic [14:0] RST_BASE   = 15'd16384;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_PROP   = 3'd1,
        REG_INTEG  = 3'd2,
        REG_PERIOD = 3'd3,
        REG_LOW    = 3'd4,
        REG_HIGH   = 3'd5,
        REG_BASE   = 3'd6
    } reg_index_t;

    // control store geometry
    localparam int UC_DEPTH = 10;
    localparam int UC_AW    = $clog2(UC_DEPTH);

    // multiplier operand selects
    typedef enum logic [1:0] {
        MA_KP,
        MA_KI,
        MA_PROD,
        MA_DUTY
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_ERR,
        MB_PERIOD,
        MB_PWM
    } mul_b_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR,
        OP_PROP,
        OP_INTEG,
        OP_SUM,
        OP_LIMIT,
        OP_DUTY,
        OP_EMIT
    } alu_op_t;

    // step conditions
    typedef enum logic [1:0] {
        C_NONE,
        C_WAIT_IN,
        C_WAIT_OUT
    } cond_t;

    typedef struct packed {
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        alu_op_t op;
        cond_t   cond;
        logic    last;
    } ucode_word_t;

    // handshake status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_cond_t;

    // control store program
    function automatic ucode_word_t ucode(input logic [UC_AW-1:0] step);
        ucode_word_t w;
        w = '{mul_en: 1'b0, mul_a: MA_KP, mul_b: MB_ERR, op: OP_NONE,
              cond: C_NONE, last: 1'b0};
        case (step)
            // take a sample, form the error
            4'd0: begin
                w.op   = OP_ERR;
                w.cond = C_WAIT_IN;
            end
            // kp * err
            4'd1: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_KP;
                w.mul_b  = MB_ERR;
            end
            // ki * err, store proportional term
            4'd2: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_KI;
                w.mul_b  = MB_ERR;
                w.op     = OP_PROP;
            end
            // (ki * err) * period
            4'd3: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_PROD;
                w.mul_b  = MB_PERIOD;
            end
            4'd4: w.op = OP_INTEG;
            4'd5: w.op = OP_SUM;
            4'd6: w.op = OP_LIMIT;
            4'd7: w.op = OP_DUTY;
            // duty * pwm scale
            4'd8: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_DUTY;
                w.mul_b  = MB_PWM;
            end
            // load output register, back to the top
            4'd9: begin
                w.op   = OP_EMIT;
                w.cond = C_WAIT_OUT;
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/pdr_seq.sv
// control-store sequencer: step counter, program lookup and conditional hold
module pdr_seq
    import pdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_cond_t   cond,
    output ucode_word_t cw,
    output logic        go
);

    logic [UC_AW-1:0] step_reg;
    logic [UC_AW-1:0] step_next;

    // current control word
    assign cw = ucode(step_reg);

    // step condition
    always_comb
    begin
        case (cw.cond)
            C_NONE:     go = 1'b1;
            C_WAIT_IN:  go = cond.in_valid;
            C_WAIT_OUT: go = cond.out_free;
            default:    go = 1'b0;
        endcase
    end

    // advance, hold or wrap
    always_comb
    begin
        if (!go)
        begin
            step_next = step_reg;
        end
        else if (cw.last)
        begin
            step_next = '0;
        end
        else
        begin
            step_next = step_reg + UC_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### rtl/pi_duty_regulator.sv
// pi duty regulator: microcoded pi loop with clamping anti-windup and pwm scaling
// flow: one sample at a time; a new sample is taken only after the previous result
//   has been loaded at the last step of the 10-step program that shares one 33x17
//   multiplier; a stalled result holds the last step
// reset: registers take their default values, the integrator clears to zero,
//   and the sequencer waits at its first step ready for a sample
module pi_duty_regulator
    import pdr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        sample_level,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] ctrl_out,
    output logic [14:0]        duty_val,
    output logic [15:0]        pwm_word,
    output logic               out_limited
);

    localparam logic signed [17:0] DUTY_LO_S = 18'(DUTY_LO);
    localparam logic signed [17:0] DUTY_HI_S = 18'(DUTY_HI);

    // configuration registers
    logic [15:0]        target_reg;
    logic signed [15:0] prop_gain_reg;
    logic signed [15:0] integ_gain_reg;
    logic [15:0]        period_reg;
    logic signed [15:0] out_low_reg;
    logic signed [15:0] out_high_reg;
    logic [14:0]        base_reg;

    // datapath registers
    logic signed [16:0] err_reg;
    logic signed [27:0] prop_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic signed [32:0] sum_reg;
    logic signed [15:0] ctrl_reg;
    logic               lim_reg;
    logic [14:0]        duty_reg;
    logic signed [49:0] prod_reg;
    logic               out_valid_reg;

    ucode_word_t        cw;
    logic               go;
    seq_cond_t          cond;

    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [32:0] isum;
    logic signed [17:0] dsum;

    // sequencer
    assign cond.in_valid = in_valid;
    assign cond.out_free = !out_valid_reg || !out_stall;

    pdr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .cw    (cw),
        .go    (go)
    );

    assign in_stall  = (cw.cond != C_WAIT_IN);
    assign out_valid = out_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= RST_TARGET;
            prop_gain_reg  <= RST_PROP;
            integ_gain_reg <= RST_INTEG;
            period_reg     <= RST_PERIOD;
            out_low_reg    <= RST_LOW;
            out_high_reg   <= RST_HIGH;
            base_reg       <= RST_BASE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET: target_reg     <= cfg_data;
                REG_PROP:   prop_gain_reg  <= cfg_data;
                REG_INTEG:  integ_gain_reg <= cfg_data;
                REG_PERIOD: period_reg     <= cfg_data;
                REG_LOW:    out_low_reg    <= cfg_data;
                REG_HIGH:   out_high_reg   <= cfg_data;
                REG_BASE:   base_reg       <= cfg_data[14:0];
                default:    ;
            endcase
        end
    end

    // shared multiplier operands
    always_comb
    begin
        case (cw.mul_a)
            MA_KP:   mul_a = 33'(prop_gain_reg);
            MA_KI:   mul_a = 33'(integ_gain_reg);
            MA_PROD: mul_a = $signed(prod_reg[32:0]);
            MA_DUTY: mul_a = $signed({18'd0, duty_reg});
            default: mul_a = '0;
        endcase
        case (cw.mul_b)
            MB_ERR:    mul_b = err_reg;
            MB_PERIOD: mul_b = $signed({1'b0, period_reg});
            MB_PWM:    mul_b = $signed(PWM_MAX);
            default:   mul_b = '0;
        endcase
    end

    assign mul_p = 50'(mul_a) * 50'(mul_b);

    // integrator update with 32-bit saturation
    assign isum = 33'(acc_reg) + 33'($signed(prod_reg[48:21]));

    always_comb
    begin
        if (isum[32] != isum[31])
        begin
            acc_next = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            acc_next = isum[31:0];
        end
    end

    // duty before clamping
    assign dsum = $signed({3'd0, base_reg}) + 18'(ctrl_reg);

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (go && cw.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (go)
        begin
            case (cw.op)
                OP_ERR:  err_reg <= $signed({1'b0, target_reg}) - $signed({1'b0, sample_level});
                OP_PROP: prop_reg <= $signed(prod_reg[32:5]);
                OP_SUM:  sum_reg <= 33'(prop_reg) + 33'(acc_reg);
                OP_LIMIT:
                begin
                    if (sum_reg > 33'(out_high_reg))
                    begin
                        ctrl_reg <= out_high_reg;
                        lim_reg  <= 1'b1;
                    end
                    else if (sum_reg < 33'(out_low_reg))
                    begin
                        ctrl_reg <= out_low_reg;
                        lim_reg  <= 1'b1;
                    end
                    else
                    begin
                        ctrl_reg <= sum_reg[15:0];
                        lim_reg  <= 1'b0;
                    end
                end
                OP_DUTY:
                begin
                    if (dsum < DUTY_LO_S)
                    begin
                        duty_reg <= DUTY_LO_S[14:0];
                    end
                    else if (dsum > DUTY_HI_S)
                    begin
                        duty_reg <= DUTY_HI_S[14:0];
                    end
                    else
                    begin
                        duty_reg <= dsum[14:0];
                    end
                end
                OP_EMIT:
                begin
                    ctrl_out    <= ctrl_reg;
                    duty_val    <= duty_reg;
                    pwm_word    <= 16'(prod_reg[PWM_BITS+14:15]);
                    out_limited <= lim_reg;
                end
                default: ;
            endcase
        end
    end

    // integrator state and anti-windup reload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (go && cw.op == OP_INTEG)
        begin
            acc_reg <= acc_next;
        end
        else if (go && cw.op == OP_LIMIT)
        begin
            if (sum_reg > 33'(out_high_reg))
            begin
                acc_reg <= 32'(out_high_reg) - 32'(prop_reg);
            end
            else if (sum_reg < 33'(out_low_reg))
            begin
                acc_reg <= 32'(out_low_reg) - 32'(prop_reg);
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && cw.op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

### rtl/pdr_checker.sv
// port-level checker for the pi duty regulator and its bind
module pdr_checker
    import pdr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] ctrl_out,
    input logic [14:0]        duty_val,
    input logic [15:0]        pwm_word,
    input logic               out_limited
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(duty_val) && $stable(pwm_word)
            && $stable(ctrl_out) && $stable(out_limited))
        else $error("result payload changed while stalled");

    // one sample in flight: stalled right after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while busy");

    // duty stays within limits and pwm follows it
    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_val >= 15'(DUTY_LO) && duty_val <= 15'(DUTY_HI)
            && pwm_word == 16'((32'(duty_val) * 32'(PWM_MAX)) >> 15))
        else $error("duty or pwm word out of step");

endmodule

bind pi_duty_regulator pdr_checker u_pdr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ctrl_out    (ctrl_out),
    .duty_val    (duty_val),
    .pwm_word    (pwm_word),
    .out_limited (out_limited)
);

### sim/tb_top.sv
// self-checking testbench for the pi duty regulator: directed cases, back-pressure, random phases
`timescale 1ns / 100ps

module tb_top;
    import pdr_pkg::*;

    // run control
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 85;

    // a register index past the end of the register file
    localparam logic [2:0] IDX_UNUSED = 3'd7;

    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    typedef enum int {
        CFG_MAX,
        CFG_MIN,
        CFG_GENTLE,
        CFG_WILD
    } cfg_style_t;

    // one regulator output transaction
    typedef struct {
        logic signed [15:0] ctrl;
        logic [14:0]        duty;
        logic [15:0]        pwm;
        logic               lim;
    } reg_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        sample_level;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] ctrl_out;
    logic [14:0]        duty_val;
    logic [15:0]        pwm_word;
    logic               out_limited;

    // shadow copy of the register file and the integrator
    logic [15:0]        m_target;
    logic signed [15:0] m_kp;
    logic signed [15:0] m_ki;
    logic [15:0]        m_period;
    logic signed [15:0] m_low;
    logic signed [15:0] m_high;
    logic [14:0]        m_base;
    longint             m_integ;

    reg_result_t predicted_outputs[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          stall_pct = 0;
    bit          hold_request = 1'b0;

    pi_duty_regulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_level (sample_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ctrl_out     (ctrl_out),
        .duty_val     (duty_val),
        .pwm_word     (pwm_word),
        .out_limited  (out_limited)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic longint clamp_int32(input longint v);
        if (v > INT32_HI)
            return INT32_HI;
        if (v < INT32_LO)
            return INT32_LO;
        return v;
    endfunction

    // pi step with clamping anti-windup, duty limit and pwm scaling
    function automatic reg_result_t regulate_step(input logic [15:0] sample);
        longint      tgt, meas, err, kp, ki, per, lo, hi, base, scale;
        longint      prop, inc, y, duty;
        reg_result_t r;
        tgt   = longint'(m_target);
        meas  = longint'(sample);
        err   = tgt - meas;
        kp    = longint'(m_kp);
        ki    = longint'(m_ki);
        per   = longint'(m_period);
        lo    = longint'(m_low);
        hi    = longint'(m_high);
        base  = longint'(m_base);
        scale = longint'(PWM_MAX);
        prop  = (kp * err) >>> 5;
        inc   = (ki * err * per) >>> 21;
        m_integ = clamp_int32(m_integ + inc);
        y     = prop + m_integ;
        r.lim = 1'b0;
        // upper limit wins, so crossed limits always land on one of them
        if (y > hi)
        begin
            y       = hi;
            r.lim   = 1'b1;
            m_integ = clamp_int32(hi - prop);
        end
        else if (y < lo)
        begin
            y       = lo;
            r.lim   = 1'b1;
            m_integ = clamp_int32(lo - prop);
        end
        duty = base + y;
        if (duty < DUTY_LO)
            duty = DUTY_LO;
        if (duty > DUTY_HI)
            duty = DUTY_HI;
        r.ctrl = y[15:0];
        r.duty = duty[14:0];
        r.pwm  = 16'((duty * scale) >>> 15);
        return r;
    endfunction

    // sample mix: rail values, values around the setpoint, anything
    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4:
            begin
                v = int'(m_target);
                v = v + int'($urandom_range(0, 600)) - 300;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return v[15:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one sample transaction and hold it until accepted
    task automatic send_sample(input logic [15:0] level);
        in_valid     <= 1'b1;
        sample_level <= level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted_outputs.push_back(regulate_step(level));
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TARGET: m_target = data;
            REG_PROP:   m_kp     = data;
            REG_INTEG:  m_ki     = data;
            REG_PERIOD: m_period = data;
            REG_LOW:    m_low    = data;
            REG_HIGH:   m_high   = data;
            REG_BASE:   m_base   = data[14:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [15:0] tgt, input logic [15:0] kp,
                             input logic [15:0] ki, input logic [15:0] per,
                             input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] base);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_PROP, kp);
        write_reg(REG_INTEG, ki);
        write_reg(REG_PERIOD, per);
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
        write_reg(REG_BASE, base);
    endtask

    task automatic randomize_regs(input cfg_style_t style);
        logic [15:0] a, b, t;
        case (style)
            CFG_MAX:
                load_regs(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF,
                          16'h7FFF);
            // crossed limits, zero period, most negative gains
            CFG_MIN:
                load_regs(16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000,
                          16'h0000);
            // modest gains and ordered limits so the loop often stays unclamped
            CFG_GENTLE:
            begin
                a = 16'($urandom);
                b = 16'($urandom);
                if ($signed(a) > $signed(b))
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                load_regs(16'($urandom), 16'(int'($urandom_range(0, 4095)) - 2048),
                          16'(int'($urandom_range(0, 1023)) - 512),
                          16'($urandom_range(0, 65535)), a, b,
                          16'($urandom_range(4000, 28000)));
            end
            default:
                load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
        endcase
    endtask

    // bursts of random length with random gaps between them
    task automatic send_random_items(input int count, input int gap_max);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < count)
            begin
                send_sample(pick_sample());
                sent++;
                burst--;
            end
            pause_sender($urandom_range(0, gap_max));
        end
    endtask

    // receiver: stall runs of random length, plus a long hold on request
    initial
    begin
        int run_left;
        bit run_val;
        run_left  = 0;
        run_val   = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                run_val      = 1'b1;
                run_left     = LONG_HOLD;
            end
            else if (run_left <= 0)
            begin
                run_val  = ($urandom_range(0, 99) < stall_pct);
                run_left = run_val ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            out_stall <= run_val;
            run_left--;
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin : check_result
        reg_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_outputs.size() == 0)
            begin
                $display("%0t: unexpected result ctrl %h duty %h pwm %h lim %b", $time,
                         ctrl_out, duty_val, pwm_word, out_limited);
                mismatches++;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                if (ctrl_out !== want.ctrl)
                begin
                    $display("%0t: ctrl_out expected %h actual %h", $time, want.ctrl,
                             ctrl_out);
                    mismatches++;
                end
                if (duty_val !== want.duty)
                begin
                    $display("%0t: duty_val expected %h actual %h", $time, want.duty,
                             duty_val);
                    mismatches++;
                end
                if (pwm_word !== want.pwm)
                begin
                    $display("%0t: pwm_word expected %h actual %h", $time, want.pwm,
                             pwm_word);
                    mismatches++;
                end
                if (out_limited !== want.lim)
                begin
                    $display("%0t: out_limited expected %b actual %b", $time, want.lim,
                             out_limited);
                    mismatches++;
                end
            end
        end
    end

    // default registers: zero error, both rails, one lsb either side
    task automatic test_reset_values();
        send_sample(16'd6144);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'd6145);
        send_sample(16'd6143);
        wait_drained();
    endtask

    // zero-width window, crossed limits, gain extremes, unlimited loop
    task automatic test_limit_cases();
        // output pinned to zero, duty clamps at both ends
        load_regs(16'd6144, 16'd205, 16'd41, 16'd655, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000);
        wait_drained();
        write_reg(REG_BASE, 16'h7FFF);
        send_sample(16'hFFFF);
        wait_drained();
        // low limit above high limit
        write_reg(REG_LOW, 16'd1000);
        write_reg(REG_HIGH, -16'sd1000);
        write_reg(REG_BASE, 16'd16384);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'd6144);
        wait_drained();
        // largest gains and period, full output range
        load_regs(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd4000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        wait_drained();
        // small gains, settles inside the limits
        load_regs(16'd6144, 16'd64, 16'd16, 16'd655, 16'h8000, 16'h7FFF, 16'd16384);
        send_sample(16'd6144);
        send_sample(16'd6160);
        send_sample(16'd6128);
        send_sample(16'd6144);
        wait_drained();
    endtask

    // writes past the last register index change nothing
    task automatic test_unused_index();
        write_reg(IDX_UNUSED, 16'h0000);
        write_reg(IDX_UNUSED, 16'hFFFF);
        send_sample(16'd6200);
        send_sample(16'd6100);
        wait_drained();
    endtask

    // long receiver hold while the sender keeps offering transactions
    task automatic test_backpressure();
        stall_pct    = 0;
        hold_request = 1'b1;
        repeat (40) send_sample(pick_sample());
        wait_drained();
    endtask

    // sender pauses until every result is back, several times
    task automatic test_drain_pause();
        stall_pct = 30;
        repeat (4)
        begin
            repeat (5) send_sample(pick_sample());
            wait_drained();
        end
    endtask

    // random register settings with random traffic in each phase
    task automatic test_random_regulation();
        int gap_max;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
                randomize_regs(CFG_MAX);
            else if (p == 1)
                randomize_regs(CFG_MIN);
            else if (p % 3 != 0)
                randomize_regs(CFG_GENTLE);
            else
                randomize_regs(CFG_WILD);
            if ($urandom_range(0, 3) == 0)
                write_reg(IDX_UNUSED, 16'($urandom));
            stall_pct = (p % 4 == 0) ? 0 : $urandom_range(10, 70);
            gap_max   = (p % 4 == 1) ? 0 : $urandom_range(2, 12);
            send_random_items(PHASE_ITEMS, gap_max);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TARGET;
        cfg_data     = 16'h0000;
        in_valid     = 1'b0;
        sample_level = 16'h0000;
        m_target     = RST_TARGET;
        m_kp         = RST_PROP;
        m_ki         = RST_INTEG;
        m_period     = RST_PERIOD;
        m_low        = RST_LOW;
        m_high       = RST_HIGH;
        m_base       = RST_BASE;
        m_integ      = 64'sd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_limit_cases();
        test_unused_index();
        test_backpressure();
        test_drain_pause();
        test_random_regulation();

        wait_drained();
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
rtl/pdr_pkg.sv
rtl/pdr_seq.sv
rtl/pi_duty_regulator.sv
rtl/pdr_checker.sv
sim/tb_top.sv
